// File: rtl/otsu_pkg.sv
// ----------------------------------------------------------------------------
// otsu_pkg
// Shared widths, types, command codes and the controller/datapath structs
// of the Otsu threshold binarizer.
// ----------------------------------------------------------------------------
package otsu_pkg;

    localparam int MAX_PIXELS = 4194304;
    localparam int LEVELS     = 256;
    localparam int LEVEL_W    = $clog2(LEVELS);
    localparam int NUM_CH     = 3;
    localparam int CH_W       = 2;

    // histogram counts and the Otsu arithmetic
    localparam int CNT_W  = $clog2(MAX_PIXELS + 1);
    localparam int SUM_W  = CNT_W + LEVEL_W;
    localparam int AB_W   = SUM_W + CNT_W;
    localparam int P_W    = 2 * CNT_W;
    localparam int DD_W   = 2 * AB_W;
    localparam int MA_W   = DD_W;
    localparam int MB_W   = AB_W;
    localparam int PROD_W = MA_W + MB_W;
    localparam int MCNT_W = $clog2(MB_W + 1);

    // floor(x/3) = (x*2731) >> 13 for every x up to 765
    localparam int GRAY_SUM_W  = 10;
    localparam int GRAY_PROD_W = 22;
    localparam int GRAY_MUL    = 2731;
    localparam int GRAY_SHIFT  = 13;

    typedef logic [LEVEL_W-1:0]     level_t;
    typedef logic [CH_W-1:0]        ch_t;
    typedef logic [CNT_W-1:0]       cnt_t;
    typedef logic [SUM_W-1:0]       sum_t;
    typedef logic [AB_W-1:0]        ab_t;
    typedef logic [P_W-1:0]         p_t;
    typedef logic [DD_W-1:0]        dd_t;
    typedef logic [MA_W-1:0]        ma_t;
    typedef logic [MB_W-1:0]        mb_t;
    typedef logic [PROD_W-1:0]      prod_t;
    typedef logic [MCNT_W-1:0]      mcnt_t;
    typedef logic [GRAY_SUM_W-1:0]  gray_sum_t;
    typedef logic [GRAY_PROD_W-1:0] gray_prod_t;

    localparam level_t LAST_LEVEL = level_t'(LEVELS - 1);
    localparam ch_t    LAST_CH    = ch_t'(NUM_CH - 1);
    localparam logic [7:0] PIX_ON = 8'hFF;

    typedef enum logic [1:0] {
        CMD_CLEAR    = 2'd0,
        CMD_ACCUM    = 2'd1,
        CMD_COMPUTE  = 2'd2,
        CMD_BINARIZE = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        SEL_A,
        SEL_B,
        SEL_P,
        SEL_DD,
        SEL_X,
        SEL_Y
    } mul_sel_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } item_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] threshold_red;
        logic [7:0] threshold_green;
        logic [7:0] threshold_blue;
        logic       pixels_full;
    } result_t;

    typedef struct packed {
        logic     latch_item;
        logic     clr_wr;
        logic     clr_total;
        logic     acc_rd;
        logic     acc_wr;
        logic     scan_init;
        logic     scan_rd;
        logic     sum_acc;
        logic     lvl_acc;
        logic     mul_start;
        logic     mul_latch;
        mul_sel_t mul_sel;
        logic     take_best;
        logic     store_th;
        logic     load_out;
        level_t   addr;
        ch_t      ch;
    } dp_cmd_t;

    typedef struct packed {
        cmd_t item_cmd;
        logic full;
        logic all_ch;
        logic skip;
        logic have;
        logic greater;
        logic out_free;
        logic mul_done;
    } dp_stat_t;

endpackage

// File: rtl/otsu_mul.sv
// ----------------------------------------------------------------------------
// otsu_mul
// Shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module otsu_mul (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  otsu_pkg::ma_t   op_a,
    input  otsu_pkg::mb_t   op_b,
    output logic            done,
    output otsu_pkg::prod_t product
);

    otsu_pkg::prod_t acc_reg, acc_next;
    otsu_pkg::prod_t mc_reg, mc_next;
    otsu_pkg::mb_t   mp_reg, mp_next;
    otsu_pkg::mcnt_t cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;

    always_comb
    begin
        acc_next  = acc_reg;
        mc_next   = mc_reg;
        mp_next   = mp_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next  = '0;
            mc_next   = otsu_pkg::prod_t'(op_a);
            mp_next   = op_b;
            cnt_next  = otsu_pkg::mcnt_t'(otsu_pkg::MB_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (mp_reg[0])
            begin
                acc_next = acc_reg + mc_reg;
            end
            mc_next  = mc_reg << 1;
            mp_next  = mp_reg >> 1;
            cnt_next = otsu_pkg::mcnt_t'(cnt_reg - 1'b1);
            if (cnt_reg == otsu_pkg::mcnt_t'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        mc_reg  <= mc_next;
        mp_reg  <= mp_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// File: rtl/otsu_datapath.sv
// ----------------------------------------------------------------------------
// otsu_datapath
// Histogram memories, pixel count, Otsu scan registers, thresholds and the
// output register. Acts on commands from otsu_ctrl.
// ----------------------------------------------------------------------------
module otsu_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  otsu_pkg::item_t   in_data,
    input  logic              cfg_valid,
    input  logic              cfg_data,
    input  otsu_pkg::dp_cmd_t cmd,
    output otsu_pkg::dp_stat_t stat,
    output logic              out_valid,
    input  logic              out_stall,
    output otsu_pkg::result_t out_data
);

    otsu_pkg::item_t   item_reg;
    logic              all_ch_reg;
    otsu_pkg::cnt_t    total_reg;
    otsu_pkg::level_t  th_reg [otsu_pkg::NUM_CH];

    otsu_pkg::cnt_t    n_all_reg, n1_reg;
    otsu_pkg::sum_t    s_all_reg, s1_reg;
    otsu_pkg::ab_t     a_reg, b_reg;
    otsu_pkg::p_t      p_reg, best_p_reg;
    otsu_pkg::dd_t     dd_reg, best_dd_reg;
    otsu_pkg::prod_t   x_reg, y_reg;
    otsu_pkg::level_t  best_t_reg;
    logic              have_reg;

    otsu_pkg::result_t out_reg;
    logic              out_valid_reg;

    otsu_pkg::gray_sum_t  gray_sum;
    otsu_pkg::gray_prod_t gray_prod;
    logic [7:0]           gray;

    otsu_pkg::level_t mem_addr [otsu_pkg::NUM_CH];
    logic             mem_we   [otsu_pkg::NUM_CH];
    otsu_pkg::cnt_t   mem_wdata[otsu_pkg::NUM_CH];
    otsu_pkg::cnt_t   rd_q     [otsu_pkg::NUM_CH];
    logic             mem_re;

    otsu_pkg::cnt_t   scan_cnt;
    otsu_pkg::sum_t   weighted;
    otsu_pkg::cnt_t   n2;
    otsu_pkg::ab_t    d;
    otsu_pkg::ma_t    op_a;
    otsu_pkg::mb_t    op_b;
    otsu_pkg::prod_t  product;
    logic             mul_done;
    logic             out_free;
    otsu_pkg::result_t res;
    otsu_pkg::level_t th_vis [otsu_pkg::NUM_CH];

    assign gray_sum  = {2'b00, item_reg.red} + {2'b00, item_reg.green}
                     + {2'b00, item_reg.blue};
    assign gray_prod = otsu_pkg::gray_prod_t'(gray_sum)
                     * otsu_pkg::gray_prod_t'(otsu_pkg::GRAY_MUL);
    assign gray      = gray_prod[otsu_pkg::GRAY_SHIFT +: 8];

    // ---- histogram memories ----
    assign mem_re = cmd.acc_rd | cmd.scan_rd;

    always_comb
    begin
        for (int c = 0; c < otsu_pkg::NUM_CH; c++)
        begin
            mem_we[c]    = cmd.clr_wr | (cmd.acc_wr & ((c == 0) | all_ch_reg));
            mem_wdata[c] = cmd.clr_wr ? '0 : otsu_pkg::cnt_t'(rd_q[c] + 1'b1);
        end
        if (cmd.clr_wr | cmd.scan_rd)
        begin
            mem_addr[0] = cmd.addr;
            mem_addr[1] = cmd.addr;
            mem_addr[2] = cmd.addr;
        end
        else
        begin
            mem_addr[0] = all_ch_reg ? item_reg.red : gray;
            mem_addr[1] = item_reg.green;
            mem_addr[2] = item_reg.blue;
        end
    end

    for (genvar c = 0; c < otsu_pkg::NUM_CH; c++)
    begin : g_hist
        otsu_pkg::cnt_t hist_mem [otsu_pkg::LEVELS];

        always_ff @(posedge clk)
        begin
            if (mem_we[c])
            begin
                hist_mem[mem_addr[c]] <= mem_wdata[c];
            end
            if (mem_re)
            begin
                rd_q[c] <= hist_mem[mem_addr[c]];
            end
        end
    end

    // ---- scan arithmetic ----
    always_comb
    begin
        unique case (cmd.ch)
            2'd1:    scan_cnt = rd_q[1];
            2'd2:    scan_cnt = rd_q[2];
            default: scan_cnt = rd_q[0];
        endcase
    end

    assign weighted = otsu_pkg::sum_t'(cmd.addr) * otsu_pkg::sum_t'(scan_cnt);
    assign n2       = otsu_pkg::cnt_t'(n_all_reg - n1_reg);
    assign d        = (a_reg >= b_reg) ? otsu_pkg::ab_t'(a_reg - b_reg)
                                       : otsu_pkg::ab_t'(b_reg - a_reg);

    always_comb
    begin
        unique case (cmd.mul_sel)
            otsu_pkg::SEL_A:
            begin
                op_a = otsu_pkg::ma_t'(s1_reg);
                op_b = otsu_pkg::mb_t'(n_all_reg);
            end
            otsu_pkg::SEL_B:
            begin
                op_a = otsu_pkg::ma_t'(s_all_reg);
                op_b = otsu_pkg::mb_t'(n1_reg);
            end
            otsu_pkg::SEL_P:
            begin
                op_a = otsu_pkg::ma_t'(n1_reg);
                op_b = otsu_pkg::mb_t'(n2);
            end
            otsu_pkg::SEL_DD:
            begin
                op_a = otsu_pkg::ma_t'(d);
                op_b = otsu_pkg::mb_t'(d);
            end
            otsu_pkg::SEL_X:
            begin
                op_a = otsu_pkg::ma_t'(dd_reg);
                op_b = otsu_pkg::mb_t'(best_p_reg);
            end
            otsu_pkg::SEL_Y:
            begin
                op_a = otsu_pkg::ma_t'(best_dd_reg);
                op_b = otsu_pkg::mb_t'(p_reg);
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    otsu_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.mul_start),
        .op_a    (op_a),
        .op_b    (op_b),
        .done    (mul_done),
        .product (product)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.latch_item)
        begin
            item_reg <= in_data;
        end
        if (cmd.scan_init)
        begin
            n_all_reg  <= '0;
            s_all_reg  <= '0;
            n1_reg     <= '0;
            s1_reg     <= '0;
            best_t_reg <= '0;
        end
        if (cmd.sum_acc)
        begin
            n_all_reg <= otsu_pkg::cnt_t'(n_all_reg + scan_cnt);
            s_all_reg <= otsu_pkg::sum_t'(s_all_reg + weighted);
        end
        if (cmd.lvl_acc)
        begin
            n1_reg <= otsu_pkg::cnt_t'(n1_reg + scan_cnt);
            s1_reg <= otsu_pkg::sum_t'(s1_reg + weighted);
        end
        if (cmd.mul_latch)
        begin
            unique case (cmd.mul_sel)
                otsu_pkg::SEL_A:  a_reg  <= product[otsu_pkg::AB_W-1:0];
                otsu_pkg::SEL_B:  b_reg  <= product[otsu_pkg::AB_W-1:0];
                otsu_pkg::SEL_P:  p_reg  <= product[otsu_pkg::P_W-1:0];
                otsu_pkg::SEL_DD: dd_reg <= product[otsu_pkg::DD_W-1:0];
                otsu_pkg::SEL_X:  x_reg  <= product;
                otsu_pkg::SEL_Y:  y_reg  <= product;
                default:          y_reg  <= product;
            endcase
        end
        if (cmd.take_best)
        begin
            best_dd_reg <= dd_reg;
            best_p_reg  <= p_reg;
            best_t_reg  <= cmd.addr;
        end
    end

    // ---- control state ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            all_ch_reg    <= 1'b0;
            total_reg     <= '0;
            have_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < otsu_pkg::NUM_CH; c++)
            begin
                th_reg[c] <= '0;
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                all_ch_reg <= cfg_data;
            end
            if (cmd.clr_total)
            begin
                total_reg <= '0;
            end
            else if (cmd.acc_wr)
            begin
                total_reg <= otsu_pkg::cnt_t'(total_reg + 1'b1);
            end
            if (cmd.scan_init)
            begin
                have_reg <= 1'b0;
            end
            else if (cmd.take_best)
            begin
                have_reg <= 1'b1;
            end
            if (cmd.store_th)
            begin
                for (int c = 0; c < otsu_pkg::NUM_CH; c++)
                begin
                    if (!all_ch_reg || (cmd.ch == otsu_pkg::ch_t'(c)))
                    begin
                        th_reg[c] <= best_t_reg;
                    end
                end
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---- result ----
    always_comb
    begin
        for (int c = 0; c < otsu_pkg::NUM_CH; c++)
        begin
            th_vis[c] = all_ch_reg ? th_reg[c] : th_reg[0];
        end
        res.threshold_red   = th_vis[0];
        res.threshold_green = th_vis[1];
        res.threshold_blue  = th_vis[2];
        res.pixels_full     = (total_reg >= otsu_pkg::cnt_t'(otsu_pkg::MAX_PIXELS));
        res.out_red         = '0;
        res.out_green       = '0;
        res.out_blue        = '0;
        if (item_reg.cmd == otsu_pkg::CMD_BINARIZE)
        begin
            if (all_ch_reg)
            begin
                res.out_red   = (item_reg.red   < th_vis[0]) ? '0 : otsu_pkg::PIX_ON;
                res.out_green = (item_reg.green < th_vis[1]) ? '0 : otsu_pkg::PIX_ON;
                res.out_blue  = (item_reg.blue  < th_vis[2]) ? '0 : otsu_pkg::PIX_ON;
            end
            else
            begin
                res.out_red   = (gray < th_vis[0]) ? '0 : otsu_pkg::PIX_ON;
                res.out_green = res.out_red;
                res.out_blue  = res.out_red;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_reg <= res;
        end
    end

    assign out_free = !out_valid_reg || !out_stall;

    assign stat.item_cmd = item_reg.cmd;
    assign stat.full     = (total_reg >= otsu_pkg::cnt_t'(otsu_pkg::MAX_PIXELS));
    assign stat.all_ch   = all_ch_reg;
    assign stat.skip     = (n1_reg == '0) || (n2 == '0);
    assign stat.have     = have_reg;
    assign stat.greater  = (x_reg > y_reg);
    assign stat.out_free = out_free;
    assign stat.mul_done = mul_done;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// File: rtl/otsu_ctrl.sv
// ----------------------------------------------------------------------------
// otsu_ctrl
// Sequencer: reset sweep, clear sweep, accumulate read-modify-write and the
// two-pass Otsu scan with its multiply steps.
// ----------------------------------------------------------------------------
module otsu_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  otsu_pkg::dp_stat_t stat,
    output otsu_pkg::dp_cmd_t  cmd
);

    typedef enum logic [4:0] {
        ST_INIT,
        ST_IDLE,
        ST_DISPATCH,
        ST_CLR,
        ST_ACC_RD,
        ST_ACC_WR,
        ST_SCAN_INIT,
        ST_SUM_RD,
        ST_SUM_ACC,
        ST_LVL_RD,
        ST_LVL_ACC,
        ST_LVL_CHK,
        ST_A_GO,
        ST_A_WT,
        ST_B_GO,
        ST_B_WT,
        ST_P_GO,
        ST_P_WT,
        ST_DD_GO,
        ST_DD_WT,
        ST_X_GO,
        ST_X_WT,
        ST_Y_GO,
        ST_Y_WT,
        ST_CMP,
        ST_TAKE,
        ST_NEXT,
        ST_STORE,
        ST_DONE
    } state_t;

    state_t           state_reg, state_next;
    otsu_pkg::level_t t_reg, t_next;
    otsu_pkg::ch_t    ch_reg, ch_next;

    always_comb
    begin
        state_next = state_reg;
        t_next     = t_reg;
        ch_next    = ch_reg;
        cmd        = '0;
        cmd.addr   = t_reg;
        cmd.ch     = ch_reg;
        in_stall   = 1'b1;

        unique case (state_reg)
            ST_INIT:
            begin
                cmd.clr_wr = 1'b1;
                t_next     = otsu_pkg::level_t'(t_reg + 1'b1);
                if (t_reg == otsu_pkg::LAST_LEVEL)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.latch_item = 1'b1;
                    state_next     = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                t_next = '0;
                unique case (stat.item_cmd)
                    otsu_pkg::CMD_CLEAR:
                    begin
                        cmd.clr_total = 1'b1;
                        state_next    = ST_CLR;
                    end
                    otsu_pkg::CMD_ACCUM:
                    begin
                        state_next = stat.full ? ST_DONE : ST_ACC_RD;
                    end
                    otsu_pkg::CMD_COMPUTE:
                    begin
                        ch_next    = '0;
                        state_next = ST_SCAN_INIT;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_CLR:
            begin
                cmd.clr_wr = 1'b1;
                t_next     = otsu_pkg::level_t'(t_reg + 1'b1);
                if (t_reg == otsu_pkg::LAST_LEVEL)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_ACC_RD:
            begin
                cmd.acc_rd = 1'b1;
                state_next = ST_ACC_WR;
            end
            ST_ACC_WR:
            begin
                cmd.acc_wr = 1'b1;
                state_next = ST_DONE;
            end
            ST_SCAN_INIT:
            begin
                cmd.scan_init = 1'b1;
                t_next        = '0;
                state_next    = ST_SUM_RD;
            end
            ST_SUM_RD:
            begin
                cmd.scan_rd = 1'b1;
                state_next  = ST_SUM_ACC;
            end
            ST_SUM_ACC:
            begin
                cmd.sum_acc = 1'b1;
                t_next      = otsu_pkg::level_t'(t_reg + 1'b1);
                state_next  = (t_reg == otsu_pkg::LAST_LEVEL) ? ST_LVL_RD : ST_SUM_RD;
            end
            ST_LVL_RD:
            begin
                cmd.scan_rd = 1'b1;
                state_next  = ST_LVL_ACC;
            end
            ST_LVL_ACC:
            begin
                cmd.lvl_acc = 1'b1;
                state_next  = ST_LVL_CHK;
            end
            ST_LVL_CHK:
            begin
                state_next = stat.skip ? ST_NEXT : ST_A_GO;
            end
            ST_A_GO:
            begin
                cmd.mul_sel   = otsu_pkg::SEL_A;
                cmd.mul_start = 1'b1;
                state_next    = ST_A_WT;
            end
            ST_A_WT:
            begin
                cmd.mul_sel = otsu_pkg::SEL_A;
                if (stat.mul_done)
                begin
                    cmd.mul_latch = 1'b1;
                    state_next    = ST_B_GO;
                end
            end
            ST_B_GO:
            begin
                cmd.mul_sel   = otsu_pkg::SEL_B;
                cmd.mul_start = 1'b1;
                state_next    = ST_B_WT;
            end
            ST_B_WT:
            begin
                cmd.mul_sel = otsu_pkg::SEL_B;
                if (stat.mul_done)
                begin
                    cmd.mul_latch = 1'b1;
                    state_next    = ST_P_GO;
                end
            end
            ST_P_GO:
            begin
                cmd.mul_sel   = otsu_pkg::SEL_P;
                cmd.mul_start = 1'b1;
                state_next    = ST_P_WT;
            end
            ST_P_WT:
            begin
                cmd.mul_sel = otsu_pkg::SEL_P;
                if (stat.mul_done)
                begin
                    cmd.mul_latch = 1'b1;
                    state_next    = ST_DD_GO;
                end
            end
            ST_DD_GO:
            begin
                cmd.mul_sel   = otsu_pkg::SEL_DD;
                cmd.mul_start = 1'b1;
                state_next    = ST_DD_WT;
            end
            ST_DD_WT:
            begin
                cmd.mul_sel = otsu_pkg::SEL_DD;
                if (stat.mul_done)
                begin
                    cmd.mul_latch = 1'b1;
                    state_next    = stat.have ? ST_X_GO : ST_TAKE;
                end
            end
            ST_X_GO:
            begin
                cmd.mul_sel   = otsu_pkg::SEL_X;
                cmd.mul_start = 1'b1;
                state_next    = ST_X_WT;
            end
            ST_X_WT:
            begin
                cmd.mul_sel = otsu_pkg::SEL_X;
                if (stat.mul_done)
                begin
                    cmd.mul_latch = 1'b1;
                    state_next    = ST_Y_GO;
                end
            end
            ST_Y_GO:
            begin
                cmd.mul_sel   = otsu_pkg::SEL_Y;
                cmd.mul_start = 1'b1;
                state_next    = ST_Y_WT;
            end
            ST_Y_WT:
            begin
                cmd.mul_sel = otsu_pkg::SEL_Y;
                if (stat.mul_done)
                begin
                    cmd.mul_latch = 1'b1;
                    state_next    = ST_CMP;
                end
            end
            ST_CMP:
            begin
                // strictly greater only: ties keep the earlier level
                state_next = stat.greater ? ST_TAKE : ST_NEXT;
            end
            ST_TAKE:
            begin
                cmd.take_best = 1'b1;
                state_next    = ST_NEXT;
            end
            ST_NEXT:
            begin
                if (t_reg == otsu_pkg::LAST_LEVEL)
                begin
                    state_next = ST_STORE;
                end
                else
                begin
                    t_next     = otsu_pkg::level_t'(t_reg + 1'b1);
                    state_next = ST_LVL_RD;
                end
            end
            ST_STORE:
            begin
                cmd.store_th = 1'b1;
                if (stat.all_ch && (ch_reg != otsu_pkg::LAST_CH))
                begin
                    ch_next    = otsu_pkg::ch_t'(ch_reg + 1'b1);
                    state_next = ST_SCAN_INIT;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            t_reg     <= '0;
            ch_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            t_reg     <= t_next;
            ch_reg    <= ch_next;
        end
    end

endmodule

// File: rtl/otsu_threshold_binarizer_top.sv
// ----------------------------------------------------------------------------
// otsu_threshold_binarizer_top
// Histogram build, Otsu threshold search and pixel binarization.
//
//   channel | direction | handshake          | payload
//   in      | sink      | in_valid/in_stall  | otsu_pkg::item_t
//   out     | source    | out_valid/out_stall| otsu_pkg::result_t
//   cfg     | sink      | cfg_valid/cfg_ready| all_channels (1 bit)
//
// One item at a time, from accept to result loaded. Clear sweeps the memory;
// accumulate reads and writes back the count, skipped once full. Compute
// scans and stores per histogram, and per level with both classes non-empty
// takes 4 or 6 products.
// After reset a sweep zeroes the histograms before the first item.
// The next item is taken while a result still waits under out_stall.
// ----------------------------------------------------------------------------
module otsu_threshold_binarizer_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  otsu_pkg::item_t   in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output otsu_pkg::result_t out_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_data
);

    otsu_pkg::dp_cmd_t  cmd;
    otsu_pkg::dp_stat_t stat;

    assign cfg_ready = 1'b1;

    otsu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    otsu_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_valid (cfg_valid & cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// File: rtl/otsu_checker.sv
// ----------------------------------------------------------------------------
// otsu_checker
// Port-level checks on the binarizer, bound to the top level.
// ----------------------------------------------------------------------------
module otsu_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input otsu_pkg::item_t   in_data,
    input logic              out_valid,
    input logic              out_stall,
    input otsu_pkg::result_t out_data
);

    // a stalled result item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // a stalled input item holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(in_data))
        else $error("stalled input changed");

    // one item in flight: busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("item accepted while previous one still in work");

    // results only come out of work on an accepted item
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without an item in work");

endmodule

bind otsu_threshold_binarizer_top otsu_checker u_otsu_checker (.*);

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the Otsu binarizer with clear / accumulate / compute / binarize
// phases in gray and all-channels mode under random idling and stalls, and
// checks every result item against a scoreboard that keeps its own
// histograms and computes the exact Otsu thresholds itself.
// ----------------------------------------------------------------------------
module testbench;
    import otsu_pkg::*;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    in_valid = 1'b0;
    logic    in_stall;
    item_t   in_data = '0;
    logic    out_valid;
    logic    out_stall = 1'b0;
    result_t out_data;
    logic    cfg_valid = 1'b0;
    logic    cfg_ready;
    logic    cfg_data = 1'b0;

    bit quiet = 1'b0;
    int n_items = 0;
    int n_compute[2];
    int n_bin = 0;
    int n_acc = 0;

    always #6 clk = ~clk;

    otsu_threshold_binarizer_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    class otsu_scoreboard;
        int unsigned hist[3*256];
        int unsigned total;
        bit [7:0]    thr[3];
        bit          per_colour;
        result_t     awaited[$];
        int          errors;
        int          checked;

        function new();
            foreach (hist[i]) hist[i] = 0;
            total = 0;
            thr[0] = 0; thr[1] = 0; thr[2] = 0;
            per_colour = 0;
            errors = 0;
            checked = 0;
        endfunction

        function bit [7:0] best_split(int base);
            longint unsigned n_all, s_all, n1, s1, n2, a, b, d, p, bd, bp;
            bit [191:0] x, y, d_w, p_w, bd_w, bp_w;
            bit [7:0] bt;
            bit have;
            n_all = 0; s_all = 0; n1 = 0; s1 = 0;
            bd = 0; bp = 1; bt = 0; have = 0;
            for (int t = 0; t < 256; t++)
            begin
                n_all += hist[base+t];
                s_all += longint'(t) * hist[base+t];
            end
            for (int t = 0; t < 256; t++)
            begin
                n1 += hist[base+t];
                s1 += longint'(t) * hist[base+t];
                n2 = n_all - n1;
                if (n1 != 0 && n2 != 0)
                begin
                    a = s1 * n_all;
                    b = s_all * n1;
                    d = (a >= b) ? a - b : b - a;
                    p = n1 * n2;
                    if (!have)
                    begin
                        have = 1; bd = d; bp = p; bt = t[7:0];
                    end
                    else
                    begin
                        d_w = d; p_w = p; bd_w = bd; bp_w = bp;
                        x = d_w * d_w * bp_w;
                        y = bd_w * bd_w * p_w;
                        if (x > y)
                        begin
                            bd = d; bp = p; bt = t[7:0];
                        end
                    end
                end
            end
            return bt;
        endfunction

        function void note_item(item_t it);
            bit [9:0] sum;
            bit [7:0] gray, t0, t1, t2;
            result_t r;
            sum = 10'(it.red) + 10'(it.green) + 10'(it.blue);
            gray = 8'(sum / 3);
            r = '0;
            case (it.cmd)
                CMD_CLEAR:
                begin
                    foreach (hist[i]) hist[i] = 0;
                    total = 0;
                end
                CMD_ACCUM:
                begin
                    if (total < MAX_PIXELS)
                    begin
                        if (per_colour)
                        begin
                            hist[it.red]++;
                            hist[256 + it.green]++;
                            hist[512 + it.blue]++;
                        end
                        else
                            hist[gray]++;
                        total++;
                    end
                end
                CMD_COMPUTE:
                begin
                    if (per_colour)
                    begin
                        for (int c = 0; c < 3; c++) thr[c] = best_split(c * 256);
                    end
                    else
                    begin
                        thr[0] = best_split(0);
                        thr[1] = thr[0];
                        thr[2] = thr[0];
                    end
                end
                default: ;
            endcase
            t0 = thr[0];
            t1 = per_colour ? thr[1] : thr[0];
            t2 = per_colour ? thr[2] : thr[0];
            if (it.cmd == CMD_BINARIZE)
            begin
                if (per_colour)
                begin
                    r.out_red   = (it.red   < t0) ? 8'd0 : PIX_ON;
                    r.out_green = (it.green < t1) ? 8'd0 : PIX_ON;
                    r.out_blue  = (it.blue  < t2) ? 8'd0 : PIX_ON;
                end
                else
                begin
                    r.out_red   = (gray < t0) ? 8'd0 : PIX_ON;
                    r.out_green = r.out_red;
                    r.out_blue  = r.out_red;
                end
            end
            r.threshold_red   = t0;
            r.threshold_green = t1;
            r.threshold_blue  = t2;
            r.pixels_full     = (total >= MAX_PIXELS);
            awaited.insert(awaited.size(), r);
        endfunction

        task report(string what, int got, int want);
            $display("mismatch %s: got %0d, expected %0d (result %0d)",
                     what, got, want, checked);
            errors++;
        endtask

        task check_result(result_t got);
            result_t w;
            if (awaited.size() == 0)
            begin
                report("unexpected result item", 1, 0);
                return;
            end
            w = awaited.pop_front();
            if (got.out_red != w.out_red) report("out_red", got.out_red, w.out_red);
            if (got.out_green != w.out_green)
                report("out_green", got.out_green, w.out_green);
            if (got.out_blue != w.out_blue) report("out_blue", got.out_blue, w.out_blue);
            if (got.threshold_red != w.threshold_red)
                report("threshold_red", got.threshold_red, w.threshold_red);
            if (got.threshold_green != w.threshold_green)
                report("threshold_green", got.threshold_green, w.threshold_green);
            if (got.threshold_blue != w.threshold_blue)
                report("threshold_blue", got.threshold_blue, w.threshold_blue);
            if (got.pixels_full != w.pixels_full)
                report("pixels_full", got.pixels_full, w.pixels_full);
            checked++;
        endtask
    endclass

    otsu_scoreboard sb = new();

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_data);

    // receiver back-pressure in bursts
    int stall_left = 0;
    always @(posedge clk)
    begin
        if (quiet)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(1, 11);
        end
        else
        begin
            out_stall  <= 1'b0;
            stall_left <= $urandom_range(1, 20);
        end
    end

    task automatic push(cmd_t c, bit [7:0] r, bit [7:0] g, bit [7:0] b);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        in_data.cmd   <= c;
        in_data.red   <= r;
        in_data.green <= g;
        in_data.blue  <= b;
        do @(posedge clk); while (in_stall);
        sb.note_item('{cmd: c, red: r, green: g, blue: b});
        n_items++;
        if (c == CMD_COMPUTE) n_compute[sb.per_colour]++;
        if (c == CMD_BINARIZE) n_bin++;
        if (c == CMD_ACCUM) n_acc++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.awaited.size() != 0) @(posedge clk);
    endtask

    task automatic set_mode(bit m);
        drain();
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        do @(posedge clk); while (!cfg_ready);
        sb.per_colour = m;
        cfg_valid <= 1'b0;
    endtask

    // pixel inside a window of the given span, each colour its own offset
    task automatic accum_window(int n, int span);
        int lo_r, lo_g, lo_b;
        lo_r = $urandom_range(0, 256 - span);
        lo_g = $urandom_range(0, 256 - span);
        lo_b = $urandom_range(0, 256 - span);
        repeat (n)
            push(CMD_ACCUM, 8'(lo_r + $urandom_range(0, span - 1)),
                 8'(lo_g + $urandom_range(0, span - 1)),
                 8'(lo_b + $urandom_range(0, span - 1)));
    endtask

    task automatic binarize_some(int n);
        repeat (n)
        begin
            if ($urandom_range(0, 1))
                push(CMD_BINARIZE, 8'($urandom), 8'($urandom), 8'($urandom));
            else
                push(CMD_BINARIZE, sb.thr[0] + 8'($urandom_range(0, 2)) - 8'd1,
                     sb.thr[1] + 8'($urandom_range(0, 2)) - 8'd1,
                     sb.thr[2] + 8'($urandom_range(0, 2)) - 8'd1);
        end
    endtask

    initial
    begin
        int span;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: gray mode first
        push(CMD_BINARIZE, 8'd0, 8'd0, 8'd0);
        push(CMD_COMPUTE, 8'd0, 8'd0, 8'd0);          // empty histogram
        push(CMD_ACCUM, 8'd7, 8'd7, 8'd7);
        push(CMD_COMPUTE, 8'd0, 8'd0, 8'd0);          // single level, no split
        push(CMD_ACCUM, 8'd255, 8'd255, 8'd255);
        push(CMD_ACCUM, 8'd0, 8'd0, 8'd0);
        push(CMD_ACCUM, 8'd255, 8'd0, 8'd1);
        push(CMD_COMPUTE, 8'd255, 8'd255, 8'd255);    // full span
        push(CMD_BINARIZE, 8'd255, 8'd255, 8'd255);
        push(CMD_BINARIZE, 8'd85, 8'd85, 8'd86);
        push(CMD_CLEAR, 8'd255, 8'd255, 8'd255);
        // two equal bins: flat variance, earliest level wins
        push(CMD_ACCUM, 8'd10, 8'd10, 8'd10);
        push(CMD_ACCUM, 8'd20, 8'd20, 8'd20);
        push(CMD_COMPUTE, 8'd0, 8'd0, 8'd0);
        push(CMD_BINARIZE, 8'd9, 8'd10, 8'd10);
        // mode switch on a gray histogram
        set_mode(1'b1);
        push(CMD_COMPUTE, 8'd0, 8'd0, 8'd0);
        push(CMD_BINARIZE, 8'd170, 8'd85, 8'd0);
        push(CMD_CLEAR, 8'd0, 8'd0, 8'd0);
        push(CMD_ACCUM, 8'd0, 8'd255, 8'd128);
        push(CMD_ACCUM, 8'd255, 8'd0, 8'd127);
        push(CMD_ACCUM, 8'd1, 8'd254, 8'd64);
        push(CMD_COMPUTE, 8'd0, 8'd0, 8'd0);
        push(CMD_BINARIZE, 8'd255, 8'd0, 8'd128);
        set_mode(1'b0);
        push(CMD_BINARIZE, 8'd100, 8'd200, 8'd50);

        // random phases of clear, accumulate, compute, binarize
        while (n_items < 1250)
        begin
            if (n_items > 1100) quiet = 1'b1;
            if ($urandom_range(0, 2) == 0) set_mode(1'(($urandom)));
            if ($urandom_range(0, 7) != 0)
                push(CMD_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom));
            span = ($urandom_range(0, 24) == 0) ? 256 : $urandom_range(1, 12);
            accum_window($urandom_range(1, 40), span);
            if ($urandom_range(0, 5) == 0) drain();   // hold off until all results in
            if ($urandom_range(0, 9) != 0)
                push(CMD_COMPUTE, 8'($urandom), 8'($urandom), 8'($urandom));
            binarize_some($urandom_range(10, 40));
            // noise: stray commands between phases
            repeat ($urandom_range(0, 3))
            begin
                case ($urandom_range(0, 2))
                    0: push(CMD_ACCUM, 8'($urandom), 8'($urandom), 8'($urandom));
                    1: push(CMD_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom));
                    default: push(CMD_BINARIZE, 8'($urandom), 8'($urandom), 8'($urandom));
                endcase
            end
        end

        in_valid <= 1'b0;
        quiet = 1'b1;
        while (sb.awaited.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        $display("covered %0d items: %0d accumulate, %0d binarize", n_items, n_acc, n_bin);
        $display("thresholds computed %0d times in gray mode, %0d per colour",
                 n_compute[0], n_compute[1]);
        if (sb.errors == 0)
            $display("[otsu_threshold_binarizer_top] OK");
        else
            $display("[otsu_threshold_binarizer_top] ERROR");
        $finish;
    end

    // timeout guard; a full-span compute in all-channels mode is the longest item
    initial
    begin
        #(12.0 * 100_000_000);
        $display("timeout");
        $display("[otsu_threshold_binarizer_top] ERROR");
        $finish;
    end
endmodule
